### rtl/assert_macros.svh
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GFF_ASSERT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid flood fill check failed");

// antecedent implies consequent in the next cycle
`define GFF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid flood fill check failed");

`endif

### rtl/gff_pkg.sv
`timescale 1ns / 1ps

package gff_pkg;

	// fixed field widths
	localparam int REQ_W     = 2;
	localparam int COORD_W   = 6;
	localparam int COLOR_W   = 32;
	localparam int COUNT_W   = 13;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 1;

	// request codes, anything else reads
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FLOOD = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [COORD_W-1:0] x_index;
		logic [COORD_W-1:0] y_index;
		logic [COLOR_W-1:0] new_color;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [COLOR_W-1:0] cell_color;
		logic [COUNT_W-1:0] fill_count;
	} rsp_t;

endpackage

### rtl/grid_flood_fill_unit.sv
`timescale 1ns / 1ps

// Colour framebuffer with write, read and 4-connected flood fill requests, one result
// beat per request beat. After reset a clearing pass zeroes the frame memory one cell a
// cycle, with in_ready low; register writes are taken throughout. One request is worked
// at a time. A flood paints the seed cell unless it already holds the new colour, then
// pops each repainted cell off the fill stack and tests its neighbours in turn, repainting
// and pushing each one inside the grid that still holds the old colour. The flood's pace
// is set by the single read/write port of the frame memory, which every neighbour test
// goes through in turn. The result beat waits in an output register, and the next
// request is taken once it has been loaded there.

`include "assert_macros.svh"

module grid_flood_fill_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int COLOR_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gff_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gff_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  gff_pkg::req_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gff_pkg::rsp_t                       out_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int TW    = $clog2(CELLS + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int SW    = XW + YW;
	localparam int XCW   = ($clog2(MAX_WIDTH + 1) > gff_pkg::CFG_DATA_W) ?
		$clog2(MAX_WIDTH + 1) : gff_pkg::CFG_DATA_W;
	localparam int YCW   = ($clog2(MAX_HEIGHT + 1) > gff_pkg::CFG_DATA_W) ?
		$clog2(MAX_HEIGHT + 1) : gff_pkg::CFG_DATA_W;
	localparam int CNT_W = gff_pkg::COUNT_W;
	localparam int OUT_CW = gff_pkg::COLOR_W;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_SEED   = 8'b0000_0100,
		ST_POP    = 8'b0000_1000,
		ST_LOAD   = 8'b0001_0000,
		ST_NB_RD  = 8'b0010_0000,
		ST_NB_CHK = 8'b0100_0000,
		ST_RESULT = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	state_t                          state_q;
	logic [AW-1:0]                   clr_addr_q;
	logic [gff_pkg::CFG_DATA_W-1:0]  grid_width_q;
	logic [gff_pkg::CFG_DATA_W-1:0]  grid_height_q;
	logic [TW-1:0]                   top_q;
	logic                            out_valid_q;
	gff_pkg::rsp_t                   out_data_q;

	logic [gff_pkg::REQ_W-1:0]       req_q;
	logic [XCW-1:0]                  cx_q;
	logic [YCW-1:0]                  cy_q;
	logic [COLOR_BITS-1:0]           color_q;
	logic [COLOR_BITS-1:0]           old_q;
	logic [CNT_W-1:0]                count_q;
	logic                            status_q;
	dir_t                            dir_q;

	// frame memory and fill stack
	logic [COLOR_BITS-1:0]           frame_q [CELLS];
	logic [COLOR_BITS-1:0]           frame_rd_q;
	logic [SW-1:0]                   stack_q [CELLS];
	logic [SW-1:0]                   stack_rd_q;

	logic [XCW-1:0]                  eff_w;
	logic [YCW-1:0]                  eff_h;
	logic [XCW-1:0]                  in_x;
	logic [YCW-1:0]                  in_y;
	logic                            in_ok;
	logic                            accept;
	logic [XCW-1:0]                  nx;
	logic [YCW-1:0]                  ny;
	logic                            nb_ok;
	logic                            nb_match;
	logic                            seed_paint;
	logic                            push;
	logic [TW-1:0]                   top_dec;
	logic                            out_load;

	logic                            fr_we;
	logic                            fr_re;
	logic [AW-1:0]                   fr_addr;
	logic [COLOR_BITS-1:0]           fr_wdata;

	function automatic logic [AW-1:0] cell_addr(input logic [XCW-1:0] x,
		input logic [YCW-1:0] y);
		cell_addr = AW'(YW'(y)) * AW'(MAX_WIDTH) + AW'(XW'(x));
	endfunction

	// effective grid size, saturated at the array bounds
	assign eff_w = (XCW'(grid_width_q) > XCW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH) :
		XCW'(grid_width_q);
	assign eff_h = (YCW'(grid_height_q) > YCW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT) :
		YCW'(grid_height_q);

	assign in_x   = XCW'(in_data.x_index);
	assign in_y   = YCW'(in_data.y_index);
	assign in_ok  = (in_x < eff_w) && (in_y < eff_h);
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// neighbour of the current cell under test
	always_comb begin
		nx    = cx_q;
		ny    = cy_q;
		nb_ok = 1'b1;
		case (dir_q)
			DIR_RIGHT: nx = cx_q + XCW'(1);
			DIR_LEFT: begin
				nx    = cx_q - XCW'(1);
				nb_ok = (cx_q != '0);
			end
			DIR_DOWN: ny = cy_q + YCW'(1);
			DIR_UP: begin
				ny    = cy_q - YCW'(1);
				nb_ok = (cy_q != '0);
			end
			default: nb_ok = 1'b0;
		endcase
		nb_ok = nb_ok && (nx < eff_w) && (ny < eff_h);
	end

	assign nb_match   = (frame_rd_q == old_q);
	assign seed_paint = (req_q == gff_pkg::REQ_FLOOD) && (frame_rd_q != color_q);
	assign push       = ((state_q == ST_SEED) && seed_paint) ||
		((state_q == ST_NB_CHK) && nb_match);
	assign top_dec    = top_q - TW'(1);
	assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	// frame memory port selection
	always_comb begin
		fr_addr  = cell_addr(cx_q, cy_q);
		fr_we    = 1'b0;
		fr_re    = 1'b0;
		fr_wdata = color_q;
		unique case (state_q)
			ST_CLEAR: begin
				fr_addr  = clr_addr_q;
				fr_we    = 1'b1;
				fr_wdata = '0;
			end
			ST_IDLE: begin
				fr_addr = cell_addr(in_x, in_y);
				fr_re   = accept && in_ok;
			end
			ST_SEED: begin
				fr_we = (req_q == gff_pkg::REQ_WRITE) || seed_paint;
			end
			ST_NB_RD: begin
				fr_addr = cell_addr(nx, ny);
				fr_re   = nb_ok;
			end
			ST_NB_CHK: begin
				fr_addr = cell_addr(nx, ny);
				fr_we   = nb_match;
			end
			default: begin
				fr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			frame_q[fr_addr] <= fr_wdata;
		end
		if (fr_re) begin
			frame_rd_q <= frame_q[fr_addr];
		end
	end

	// fill stack, pushed with the painted cell, popped from the top
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[top_q[AW-1:0]] <= (state_q == ST_SEED) ?
				{YW'(cy_q), XW'(cx_q)} : {YW'(ny), XW'(nx)};
		end
		if ((state_q == ST_POP) && (top_q != '0)) begin
			stack_rd_q <= stack_q[top_dec[AW-1:0]];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			grid_width_q  <= gff_pkg::GRID_DIM_RESET;
			grid_height_q <= gff_pkg::GRID_DIM_RESET;
			top_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gff_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					gff_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (push) begin
				top_q <= top_q + TW'(1);
			end else if ((state_q == ST_POP) && (top_q != '0)) begin
				top_q <= top_dec;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_ok ? ST_SEED : ST_RESULT;
					end
				end
				ST_SEED: begin
					state_q <= seed_paint ? ST_POP : ST_RESULT;
				end
				ST_POP: begin
					state_q <= (top_q != '0) ? ST_LOAD : ST_RESULT;
				end
				ST_LOAD: begin
					state_q <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (nb_ok) begin
						state_q <= ST_NB_CHK;
					end else if (dir_q == DIR_UP) begin
						state_q <= ST_POP;
					end
				end
				ST_NB_CHK: begin
					state_q <= (dir_q == DIR_UP) ? ST_POP : ST_NB_RD;
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q    <= in_data.req_type;
					cx_q     <= in_x;
					cy_q     <= in_y;
					color_q  <= in_data.new_color[COLOR_BITS-1:0];
					old_q    <= '0;
					count_q  <= '0;
					status_q <= !in_ok;
				end
			end
			ST_SEED: begin
				old_q <= frame_rd_q;
				if (req_q == gff_pkg::REQ_WRITE) begin
					count_q <= (frame_rd_q != color_q) ? CNT_W'(1) : '0;
				end else if (seed_paint) begin
					count_q <= CNT_W'(1);
				end
			end
			ST_LOAD: begin
				cx_q  <= XCW'(stack_rd_q[XW-1:0]);
				cy_q  <= YCW'(stack_rd_q[SW-1:XW]);
				dir_q <= DIR_RIGHT;
			end
			ST_NB_RD: begin
				if (!nb_ok) begin
					dir_q <= dir_t'(dir_q + 2'd1);
				end
			end
			ST_NB_CHK: begin
				if (nb_match) begin
					count_q <= count_q + CNT_W'(1);
				end
				dir_q <= dir_t'(dir_q + 2'd1);
			end
			default: begin
			end
		endcase
	end

	// result register, parts the sequencer from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.status     <= status_q;
			out_data_q.cell_color <= OUT_CW'(old_q);
			out_data_q.fill_count <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`GFF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`GFF_ASSERT(a_stack_empty_idle, state_q == ST_IDLE, top_q == '0)
	`GFF_ASSERT(a_range_result_zero, out_valid && out_data.status, (out_data.cell_color == '0) && (out_data.fill_count == '0))
	`GFF_ASSERT_NEXT(a_result_held, (state_q == ST_RESULT) && out_valid && !out_ready, state_q == ST_RESULT)

endmodule
